// File: design/i2p_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2p_pkg;

   // Operator stack geometry.
   localparam int STACK_DEPTH = 32;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W       = $clog2(STACK_DEPTH);

   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

   // Stacked operator codes.
   localparam logic [2:0] OP_OPEN  = 3'd0;
   localparam logic [2:0] OP_PLUS  = 3'd1;
   localparam logic [2:0] OP_MINUS = 3'd2;
   localparam logic [2:0] OP_MUL   = 3'd3;
   localparam logic [2:0] OP_DIV   = 3'd4;
   localparam logic [2:0] OP_POW   = 3'd5;

   // Result kinds.
   localparam logic [1:0] KIND_SYM  = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   // Error codes.
   localparam logic [2:0] ERR_NONE  = 3'd0;
   localparam logic [2:0] ERR_BAD   = 3'd1;
   localparam logic [2:0] ERR_CLOSE = 3'd2;
   localparam logic [2:0] ERR_OPEN  = 3'd3;
   localparam logic [2:0] ERR_FULL  = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SIMPLE,
      ST_OP,
      ST_CLOSE,
      ST_END
   } state_type;

   typedef enum logic [2:0] {
      CLS_ALNUM,
      CLS_OPEN,
      CLS_CLOSE,
      CLS_OP,
      CLS_BAD
   } class_type;

   // Command to the operator stack; at most one of push, pop, clear is set.
   typedef struct packed {
      logic       push;
      logic       pop;
      logic       clear;
      logic [2:0] op;
   } stk_cmd_type;

   // One result on its way out.
   typedef struct packed {
      logic [7:0] symbol;
      logic [1:0] kind;
      logic [2:0] code;
      logic       last;
   } res_type;

endpackage

`default_nettype wire

// File: design/i2p_op_stack.sv
`timescale 1ns / 1ps
`default_nettype none

// Operator stack. Position zero is the implicit sentinel; its contents are never used.
// The top entry lives in a register; the entries below it sit in a memory
// with one write port and one registered read port.
module i2p_op_stack (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire i2p_pkg::stk_cmd_type       cmd,
   output logic [2:0]                      top_op,
   output logic [i2p_pkg::CNT_W-1:0]       count
);

   logic [2:0]                  mem [i2p_pkg::STACK_DEPTH];
   logic [2:0]                  top_ff;
   logic [i2p_pkg::CNT_W-1:0]   count_ff;
   logic [i2p_pkg::CNT_W-1:0]   count_in;
   logic [i2p_pkg::CNT_W-1:0]   below_top;
   logic [i2p_pkg::CNT_W-1:0]   below_next;
   logic [i2p_pkg::IDX_W-1:0]   wr_idx;
   logic [i2p_pkg::IDX_W-1:0]   rd_idx;

   assign below_top  = count_ff - i2p_pkg::CNT_ONE;
   assign below_next = count_ff - i2p_pkg::CNT_W'(2);
   assign wr_idx     = below_top[i2p_pkg::IDX_W-1:0];
   assign rd_idx     = below_next[i2p_pkg::IDX_W-1:0];

   always_comb begin
      priority if (cmd.clear) begin
         count_in = i2p_pkg::CNT_ONE;
      end else if (cmd.push) begin
         count_in = count_ff + i2p_pkg::CNT_ONE;
      end else if (cmd.pop) begin
         count_in = count_ff - i2p_pkg::CNT_ONE;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= i2p_pkg::CNT_ONE;
      end else begin
         count_ff <= count_in;
      end
   end

   // On a push the old top drops into the memory; on a pop the entry below
   // is read back into the top register.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[wr_idx] <= top_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         top_ff <= cmd.op;
      end else if (cmd.pop) begin
         top_ff <= mem[rd_idx];
      end
   end

   assign top_op = top_ff;
   assign count  = count_ff;

endmodule

`default_nettype wire

// File: design/infix_to_postfix_converter.sv
`timescale 1ns / 1ps
`default_nettype none

// Infix to postfix converter (shunting yard). Each request carries one ASCII
// character and a flag that marks the last character of an expression.
// Letters and digits come out at once as postfix symbols; the operators
// + - * / $ (precedence 1, 1, 2, 2, 3) first pop every stacked operator of
// equal or higher precedence, then are pushed; '(' is pushed and ')' pops
// down to its match. The last character also closes the expression: the
// leftover operators come out, then an "expression complete" result. Errors
// (bad character, unmatched ')', leftover '(', stack overflow) give one
// error result; unless that request was the last, the requests that follow
// are dropped silently up to and including the next last-flagged one.
// run_last marks the final result that a request causes; a request may
// cause none. The block takes one request at a time and takes the next only
// once it is back in idle; a dropped request is passed over in idle. The
// operator stack pops one entry per cycle and the result path moves one
// result per cycle while the result channel does not stall. The stack holds
// i2p_pkg::STACK_DEPTH entries including the bottom sentinel and needs no
// clearing pass after reset.
module infix_to_postfix_converter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_ch,
   input  wire logic        req_expr_end,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_symbol,
   output logic [1:0]       rsp_kind,
   output logic [2:0]       rsp_error_code,
   output logic             rsp_run_last
);

   function automatic i2p_pkg::class_type classify(input logic [7:0] c);
      priority if ((c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
                   (c >= "A" && c <= "Z")) begin
         return i2p_pkg::CLS_ALNUM;
      end else if (c == "(") begin
         return i2p_pkg::CLS_OPEN;
      end else if (c == ")") begin
         return i2p_pkg::CLS_CLOSE;
      end else if (c == "+" || c == "-" || c == "*" || c == "/" || c == "$") begin
         return i2p_pkg::CLS_OP;
      end else begin
         return i2p_pkg::CLS_BAD;
      end
   endfunction

   function automatic logic [2:0] op_of_char(input logic [7:0] c);
      priority if (c == "+") begin
         return i2p_pkg::OP_PLUS;
      end else if (c == "-") begin
         return i2p_pkg::OP_MINUS;
      end else if (c == "*") begin
         return i2p_pkg::OP_MUL;
      end else if (c == "/") begin
         return i2p_pkg::OP_DIV;
      end else if (c == "$") begin
         return i2p_pkg::OP_POW;
      end else begin
         return i2p_pkg::OP_OPEN;
      end
   endfunction

   function automatic logic [7:0] char_of_op(input logic [2:0] op);
      logic [7:0] c;
      unique case (op)
         i2p_pkg::OP_OPEN:  c = "(";
         i2p_pkg::OP_PLUS:  c = "+";
         i2p_pkg::OP_MINUS: c = "-";
         i2p_pkg::OP_MUL:   c = "*";
         i2p_pkg::OP_DIV:   c = "/";
         i2p_pkg::OP_POW:   c = "$";
         default:           c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [1:0] prec_of_op(input logic [2:0] op);
      logic [1:0] p;
      unique case (op)
         i2p_pkg::OP_PLUS, i2p_pkg::OP_MINUS: p = 2'd1;
         i2p_pkg::OP_MUL,  i2p_pkg::OP_DIV:   p = 2'd2;
         i2p_pkg::OP_POW:                     p = 2'd3;
         default:                             p = 2'd0;
      endcase
      return p;
   endfunction

   // Sequencer state and the latched request.
   i2p_pkg::state_type        state_ff, state_in;
   i2p_pkg::class_type        class_ff, class_in;
   logic [7:0]                ch_ff, ch_in;
   logic                      last_ff, last_in;
   logic [2:0]                opk_ff, opk_in;
   logic                      discard_ff, discard_in;

   // Operator stack.
   i2p_pkg::stk_cmd_type      cmd;
   logic [2:0]                top_op;
   logic [i2p_pkg::CNT_W-1:0] count;
   logic                      has_ops;
   logic                      full;
   logic                      top_is_op;

   // Result path: a holding stage followed by the output register. A result
   // waits in the holding stage until the sequencer knows whether it is the
   // last one of its request.
   i2p_pkg::res_type          pend_ff, pend_in;
   logic                      pend_valid_ff, pend_valid_in;
   i2p_pkg::res_type          rsp_ff, rsp_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   i2p_pkg::res_type          pend_view;
   i2p_pkg::res_type          new_res;
   logic                      out_free;
   logic                      advance;
   logic                      pend_move;
   logic                      produce;
   logic                      finish_nores;
   logic                      err_hit;
   logic [2:0]                err_val;

   i2p_op_stack u_stack (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .top_op (top_op),
      .count  (count)
   );

   assign has_ops   = (count != i2p_pkg::CNT_ONE);
   assign full      = (count >= i2p_pkg::CNT_FULL);
   assign top_is_op = (top_op != i2p_pkg::OP_OPEN);

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = !pend_valid_ff || out_free;
   assign req_ready = (state_ff == i2p_pkg::ST_IDLE);

   // Sequencer: one stack step and at most one result per cycle.
   always_comb begin
      state_in     = state_ff;
      class_in     = class_ff;
      ch_in        = ch_ff;
      last_in      = last_ff;
      opk_in       = opk_ff;
      discard_in   = discard_ff;
      cmd          = '0;
      produce      = 1'b0;
      new_res      = '0;
      finish_nores = 1'b0;
      err_hit      = 1'b0;
      err_val      = i2p_pkg::ERR_NONE;

      unique case (state_ff)
         i2p_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (discard_ff) begin
                  // Dropping input after an error; the last character
                  // ends the dropped expression and resets the stack.
                  if (req_expr_end) begin
                     discard_in = 1'b0;
                     cmd.clear  = 1'b1;
                  end
               end else begin
                  ch_in    = req_ch;
                  last_in  = req_expr_end;
                  class_in = classify(req_ch);
                  opk_in   = op_of_char(req_ch);
                  unique case (classify(req_ch))
                     i2p_pkg::CLS_OP:    state_in = i2p_pkg::ST_OP;
                     i2p_pkg::CLS_CLOSE: state_in = i2p_pkg::ST_CLOSE;
                     default:            state_in = i2p_pkg::ST_SIMPLE;
                  endcase
               end
            end
         end

         i2p_pkg::ST_SIMPLE: begin
            if (advance) begin
               unique case (class_ff)
                  i2p_pkg::CLS_ALNUM: begin
                     produce        = 1'b1;
                     new_res.symbol = ch_ff;
                     new_res.kind   = i2p_pkg::KIND_SYM;
                     new_res.last   = !last_ff;
                     state_in       = last_ff ? i2p_pkg::ST_END : i2p_pkg::ST_IDLE;
                  end
                  i2p_pkg::CLS_OPEN: begin
                     if (full) begin
                        err_hit = 1'b1;
                        err_val = i2p_pkg::ERR_FULL;
                     end else begin
                        cmd.push     = 1'b1;
                        cmd.op       = i2p_pkg::OP_OPEN;
                        finish_nores = !last_ff;
                        state_in     = last_ff ? i2p_pkg::ST_END : i2p_pkg::ST_IDLE;
                     end
                  end
                  default: begin
                     err_hit = 1'b1;
                     err_val = i2p_pkg::ERR_BAD;
                  end
               endcase
            end
         end

         i2p_pkg::ST_OP: begin
            if (advance) begin
               if (has_ops && top_is_op && (prec_of_op(top_op) >= prec_of_op(opk_ff))) begin
                  produce        = 1'b1;
                  new_res.symbol = char_of_op(top_op);
                  new_res.kind   = i2p_pkg::KIND_SYM;
                  cmd.pop        = 1'b1;
               end else if (full) begin
                  // Symbols popped before the failed push still stand.
                  err_hit = 1'b1;
                  err_val = i2p_pkg::ERR_FULL;
               end else begin
                  cmd.push     = 1'b1;
                  cmd.op       = opk_ff;
                  finish_nores = !last_ff;
                  state_in     = last_ff ? i2p_pkg::ST_END : i2p_pkg::ST_IDLE;
               end
            end
         end

         i2p_pkg::ST_CLOSE: begin
            if (advance) begin
               if (has_ops && top_is_op) begin
                  produce        = 1'b1;
                  new_res.symbol = char_of_op(top_op);
                  new_res.kind   = i2p_pkg::KIND_SYM;
                  cmd.pop        = 1'b1;
               end else if (!has_ops) begin
                  err_hit = 1'b1;
                  err_val = i2p_pkg::ERR_CLOSE;
               end else begin
                  // Drop the matching open parenthesis.
                  cmd.pop      = 1'b1;
                  finish_nores = !last_ff;
                  state_in     = last_ff ? i2p_pkg::ST_END : i2p_pkg::ST_IDLE;
               end
            end
         end

         i2p_pkg::ST_END: begin
            if (advance) begin
               if (has_ops && top_is_op) begin
                  produce        = 1'b1;
                  new_res.symbol = char_of_op(top_op);
                  new_res.kind   = i2p_pkg::KIND_SYM;
                  cmd.pop        = 1'b1;
               end else if (has_ops) begin
                  err_hit = 1'b1;
                  err_val = i2p_pkg::ERR_OPEN;
               end else begin
                  produce      = 1'b1;
                  new_res.kind = i2p_pkg::KIND_DONE;
                  new_res.last = 1'b1;
                  cmd.clear    = 1'b1;
                  state_in     = i2p_pkg::ST_IDLE;
               end
            end
         end

         default: begin
            state_in = i2p_pkg::ST_IDLE;
         end
      endcase

      // Any error ends the request with one error result. Mid-expression,
      // the rest of the expression is dropped; at its end, the stack resets.
      if (err_hit) begin
         produce        = 1'b1;
         new_res        = '0;
         new_res.kind   = i2p_pkg::KIND_ERR;
         new_res.code   = err_val;
         new_res.last   = 1'b1;
         cmd            = '0;
         cmd.clear      = last_ff;
         discard_in     = !last_ff;
         state_in       = i2p_pkg::ST_IDLE;
      end
   end

   // A request that ends without a result of its own marks the held result
   // as its last one.
   always_comb begin
      pend_view      = pend_ff;
      pend_view.last = pend_ff.last | finish_nores;
   end

   assign pend_move = pend_valid_ff && out_free && (produce || pend_view.last);

   always_comb begin
      pend_valid_in = produce || (pend_valid_ff && !pend_move);
      pend_in       = produce ? new_res : pend_view;
      rsp_valid_in  = pend_move || (rsp_valid_ff && !rsp_ready);
      rsp_in        = pend_move ? pend_view : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= i2p_pkg::ST_IDLE;
         discard_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         discard_ff    <= discard_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      class_ff <= class_in;
      ch_ff    <= ch_in;
      last_ff  <= last_in;
      opk_ff   <= opk_in;
      pend_ff  <= pend_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_symbol     = rsp_ff.symbol;
   assign rsp_kind       = rsp_ff.kind;
   assign rsp_error_code = rsp_ff.code;
   assign rsp_run_last   = rsp_ff.last;

endmodule

`default_nettype wire

// File: design/i2p_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module i2p_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [7:0] req_ch,
   input wire logic       req_expr_end,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_symbol,
   input wire logic [1:0] rsp_kind,
   input wire logic [2:0] rsp_error_code,
   input wire logic       rsp_run_last
);

   // A waiting request keeps its character and flag until it is taken.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_ch) && $stable(req_expr_end))
      else $error("waiting request changed");

   // A completion or an error always closes the results of its request.
   a_final_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != i2p_pkg::KIND_SYM) |-> rsp_run_last)
      else $error("completion or error result without run_last");

   // An error code appears exactly on error results.
   a_code_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_kind == i2p_pkg::KIND_ERR) ==
                     (rsp_error_code != i2p_pkg::ERR_NONE)))
      else $error("error code does not match result kind");

   // Only postfix symbols carry a character.
   a_symbol_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != i2p_pkg::KIND_SYM) |-> (rsp_symbol == 8'h00))
      else $error("non-symbol result carries a character");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_symbol) &&
         $stable(rsp_kind) && $stable(rsp_error_code) && $stable(rsp_run_last))
      else $error("stalled result changed");

endmodule

bind infix_to_postfix_converter i2p_checker u_i2p_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_ch         (req_ch),
   .req_expr_end   (req_expr_end),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_symbol     (rsp_symbol),
   .rsp_kind       (rsp_kind),
   .rsp_error_code (rsp_error_code),
   .rsp_run_last   (rsp_run_last)
);

`default_nettype wire

// File: dv/infix_to_postfix_converter_test.sv
`timescale 1ns / 1ps

module infix_to_postfix_converter_test;

   // ASCII characters that the converter treats as structure, and two it rejects.
   localparam logic [7:0] CH_PLUS   = "+";
   localparam logic [7:0] CH_MINUS  = "-";
   localparam logic [7:0] CH_STAR   = "*";
   localparam logic [7:0] CH_SLASH  = "/";
   localparam logic [7:0] CH_DOLLAR = "$";
   localparam logic [7:0] CH_LPAREN = "(";
   localparam logic [7:0] CH_RPAREN = ")";
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_CARET  = "^";

   // Requests to send in total, directed rows included.
   localparam int ITEMS      = 330;
   // Receivers and senders idle in about this many cycles out of a hundred.
   localparam int IDLE_PCT   = 18;
   // Window of live requests during which neither side idles.
   localparam int QUIET_LO   = 150;
   localparam int QUIET_HI   = 230;
   // The long result-channel hold-off starts once this many live requests are in.
   localparam int HOLD_AT    = 60;
   localparam int HOLD_LEN   = 400;
   localparam int DRAIN_WAIT = 40;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_ch;
   logic       req_expr_end;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_symbol;
   logic [1:0] rsp_kind;
   logic [2:0] rsp_error_code;
   logic       rsp_run_last;

   infix_to_postfix_converter u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_ch         (req_ch),
      .req_expr_end   (req_expr_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_symbol     (rsp_symbol),
      .rsp_kind       (rsp_kind),
      .rsp_error_code (rsp_error_code),
      .rsp_run_last   (rsp_run_last)
   );

   // Directed requests. Rows marked typed carry their single expected result,
   // which always ends the run of results for that request. The other rows are
   // checked against the predictor.
   typedef struct packed {
      logic [7:0] ch;
      logic       fin;
      logic       typed;
      logic [7:0] symbol;
      logic [1:0] kind;
      logic [2:0] code;
   } dir_row_type;

   localparam int DIR_ROWS = 25;

   dir_row_type dir_rows [DIR_ROWS] = '{
      // Operands at the edges of the letter and digit ranges, with every operator
      // but the slash in between; the final minus flushes the whole stack.
      '{"a",       1'b0, 1'b1, "a",   i2p_pkg::KIND_SYM, i2p_pkg::ERR_NONE},
      '{CH_PLUS,   1'b0, 1'b0, 8'h00, i2p_pkg::KIND_SYM, i2p_pkg::ERR_NONE},
      '{"Z",       1'b0, 1'b1, "Z",   i2p_pkg::KIND_SYM, i2p_pkg::ERR_NONE},
      '{CH_STAR,   1'b0, 1'b0, 8'h00, i2p_pkg::KIND_SYM, i2p_pkg::ERR_NONE},
      '{"9",       1'b0, 1'b1, "9",   i2p_pkg::KIND_SYM, i2p_pkg::ERR_NONE},
      '{CH_DOLLAR, 1'b0, 1'b0, 8'h00, i2p_pkg::KIND_SYM, i2p_pkg::ERR_NONE},
      '{"0",       1'b0, 1'b1, "0",   i2p_pkg::KIND_SYM, i2p_pkg::ERR_NONE},
      '{CH_MINUS,  1'b1, 1'b0, 8'h00, i2p_pkg::KIND_SYM, i2p_pkg::ERR_NONE},
      // Bad characters at both ends of the byte range. The second one is not
      // last, so the two requests after it are dropped without a result.
      '{8'h00,     1'b1, 1'b1, 8'h00, i2p_pkg::KIND_ERR, i2p_pkg::ERR_BAD},
      '{8'hFF,     1'b0, 1'b1, 8'h00, i2p_pkg::KIND_ERR, i2p_pkg::ERR_BAD},
      '{"a",       1'b0, 1'b0, 8'h00, i2p_pkg::KIND_SYM, i2p_pkg::ERR_NONE},
      '{"b",       1'b1, 1'b0, 8'h00, i2p_pkg::KIND_SYM, i2p_pkg::ERR_NONE},
      // A close parenthesis with nothing open.
      '{CH_RPAREN, 1'b1, 1'b1, 8'h00, i2p_pkg::KIND_ERR, i2p_pkg::ERR_CLOSE},
      // An open parenthesis left over at the end of the expression.
      '{CH_LPAREN, 1'b0, 1'b0, 8'h00, i2p_pkg::KIND_SYM, i2p_pkg::ERR_NONE},
      '{"x",       1'b1, 1'b0, 8'h00, i2p_pkg::KIND_SYM, i2p_pkg::ERR_NONE},
      // A group that closes properly, followed by the exponent operator.
      '{CH_LPAREN, 1'b0, 1'b0, 8'h00, i2p_pkg::KIND_SYM, i2p_pkg::ERR_NONE},
      '{"z",       1'b0, 1'b1, "z",   i2p_pkg::KIND_SYM, i2p_pkg::ERR_NONE},
      '{CH_SLASH,  1'b0, 1'b0, 8'h00, i2p_pkg::KIND_SYM, i2p_pkg::ERR_NONE},
      '{"A",       1'b0, 1'b1, "A",   i2p_pkg::KIND_SYM, i2p_pkg::ERR_NONE},
      '{CH_RPAREN, 1'b0, 1'b0, 8'h00, i2p_pkg::KIND_SYM, i2p_pkg::ERR_NONE},
      '{CH_DOLLAR, 1'b0, 1'b0, 8'h00, i2p_pkg::KIND_SYM, i2p_pkg::ERR_NONE},
      '{"1",       1'b1, 1'b0, 8'h00, i2p_pkg::KIND_SYM, i2p_pkg::ERR_NONE},
      // The caret is not an operator here. A space is not accepted either,
      // and the close after it is dropped while it ends the expression.
      '{CH_CARET,  1'b1, 1'b1, 8'h00, i2p_pkg::KIND_ERR, i2p_pkg::ERR_BAD},
      '{CH_SPACE,  1'b0, 1'b1, 8'h00, i2p_pkg::KIND_ERR, i2p_pkg::ERR_BAD},
      '{CH_RPAREN, 1'b1, 1'b0, 8'h00, i2p_pkg::KIND_SYM, i2p_pkg::ERR_NONE}
   };

   // Predictor state: the operator stack with its sentinel and the flag that
   // drops requests after an error.
   logic [2:0] pend_ops [i2p_pkg::STACK_DEPTH];
   int         pend_n = 1;
   bit         dropping = 1'b0;

   i2p_pkg::res_type step_q[$];      // results of the request being predicted
   i2p_pkg::res_type postfix_q[$];   // results still owed by the block
   logic [7:0]       expr_q[$];      // characters of the expression being sent

   int mismatches   = 0;
   int result_count = 0;
   int live_items   = 0;
   int sent_items   = 0;

   // Side information for the request on the bus, set along with its payload.
   logic             row_typed;
   i2p_pkg::res_type row_want;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t, result %0d: %s", $realtime, result_count, msg);
      mismatches++;
   endtask

   function automatic bit is_alnum(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic [2:0] op_of(input logic [7:0] c);
      case (c)
         CH_PLUS:   return i2p_pkg::OP_PLUS;
         CH_MINUS:  return i2p_pkg::OP_MINUS;
         CH_STAR:   return i2p_pkg::OP_MUL;
         CH_SLASH:  return i2p_pkg::OP_DIV;
         CH_DOLLAR: return i2p_pkg::OP_POW;
         default:   return i2p_pkg::OP_OPEN;
      endcase
   endfunction

   function automatic logic [7:0] char_of(input logic [2:0] op);
      case (op)
         i2p_pkg::OP_PLUS:  return CH_PLUS;
         i2p_pkg::OP_MINUS: return CH_MINUS;
         i2p_pkg::OP_MUL:   return CH_STAR;
         i2p_pkg::OP_DIV:   return CH_SLASH;
         i2p_pkg::OP_POW:   return CH_DOLLAR;
         default:           return CH_LPAREN;
      endcase
   endfunction

   function automatic int prec_of(input logic [2:0] op);
      case (op)
         i2p_pkg::OP_PLUS, i2p_pkg::OP_MINUS: return 1;
         i2p_pkg::OP_MUL, i2p_pkg::OP_DIV:    return 2;
         i2p_pkg::OP_POW:                     return 3;
         default:                             return 0;
      endcase
   endfunction

   function automatic void emit(input logic [7:0] sym, input logic [1:0] kind,
                                input logic [2:0] code);
      i2p_pkg::res_type r;
      r.symbol = sym;
      r.kind   = kind;
      r.code   = code;
      r.last   = 1'b0;
      step_q.push_back(r);
   endfunction

   // Pops operators down to the nearest open parenthesis and removes it. Returns
   // 0 when only the sentinel is left, so no group was open.
   function automatic bit close_group();
      while (pend_n > 1 && pend_ops[pend_n-1] != i2p_pkg::OP_OPEN) begin
         emit(char_of(pend_ops[pend_n-1]), i2p_pkg::KIND_SYM, i2p_pkg::ERR_NONE);
         pend_n--;
      end
      if (pend_n <= 1) return 1'b0;
      pend_n--;
      return 1'b1;
   endfunction

   // Works out the results of one request and advances the predictor state.
   function automatic void convert_char(input logic [7:0] c, input logic fin);
      logic [2:0] err;
      logic [2:0] op;
      err = i2p_pkg::ERR_NONE;
      op  = op_of(c);
      step_q.delete();
      if (dropping) begin
         if (fin) begin
            dropping = 1'b0;
            pend_n   = 1;
         end
         return;
      end
      if (c == CH_LPAREN) begin
         if (pend_n >= i2p_pkg::STACK_DEPTH) begin
            err = i2p_pkg::ERR_FULL;
         end else begin
            pend_ops[pend_n] = i2p_pkg::OP_OPEN;
            pend_n++;
         end
      end else if (is_alnum(c)) begin
         emit(c, i2p_pkg::KIND_SYM, i2p_pkg::ERR_NONE);
      end else if (op != i2p_pkg::OP_OPEN) begin
         // Higher or equal precedence leaves the stack before the push.
         while (pend_n > 1 && pend_ops[pend_n-1] != i2p_pkg::OP_OPEN
                && prec_of(pend_ops[pend_n-1]) >= prec_of(op)) begin
            emit(char_of(pend_ops[pend_n-1]), i2p_pkg::KIND_SYM, i2p_pkg::ERR_NONE);
            pend_n--;
         end
         if (pend_n >= i2p_pkg::STACK_DEPTH) begin
            err = i2p_pkg::ERR_FULL;
         end else begin
            pend_ops[pend_n] = op;
            pend_n++;
         end
      end else if (c == CH_RPAREN) begin
         if (!close_group()) err = i2p_pkg::ERR_CLOSE;
      end else begin
         err = i2p_pkg::ERR_BAD;
      end
      // The last character also closes the sentinel group; a group that is
      // still open at that point means a leftover open parenthesis.
      if (err == i2p_pkg::ERR_NONE && fin) begin
         if (close_group()) err = i2p_pkg::ERR_OPEN;
         else emit(8'h00, i2p_pkg::KIND_DONE, i2p_pkg::ERR_NONE);
      end
      if (err != i2p_pkg::ERR_NONE) begin
         emit(8'h00, i2p_pkg::KIND_ERR, err);
         if (!fin) dropping = 1'b1;
      end
      if (fin) pend_n = 1;
      if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
   endfunction

   // Both sides keep going flat out for a while in the middle of the run.
   function automatic bit quiet_window();
      return live_items >= QUIET_LO && live_items < QUIET_HI;
   endfunction

   function automatic bit sender_idles();
      return !quiet_window() && $urandom_range(0, 99) < IDLE_PCT;
   endfunction

   function automatic logic [7:0] rand_alnum();
      int r;
      r = $urandom_range(0, 61);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      return 8'("0" + r - 52);
   endfunction

   function automatic logic [7:0] rand_op();
      return char_of(3'($urandom_range(1, 5)));
   endfunction

   // Any character the converter knows, with operands the most frequent.
   function automatic logic [7:0] rand_token();
      case ($urandom_range(0, 3))
         0, 1:    return rand_alnum();
         2:       return rand_op();
         default: return $urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN;
      endcase
   endfunction

   // Appends a well-formed expression: operands joined by operators, with
   // parenthesized groups nested up to max_depth.
   task automatic gen_wellformed(input int max_depth, input int max_ops);
      int depth;
      int ops;
      depth = 0;
      ops   = 0;
      while (1) begin
         while (depth < max_depth && $urandom_range(0, 3) == 0) begin
            expr_q.push_back(CH_LPAREN);
            depth++;
         end
         expr_q.push_back(rand_alnum());
         while (depth > 0 && $urandom_range(0, 2) == 0) begin
            expr_q.push_back(CH_RPAREN);
            depth--;
         end
         if (ops >= max_ops) break;
         expr_q.push_back(rand_op());
         ops++;
      end
      while (depth > 0) begin
         expr_q.push_back(CH_RPAREN);
         depth--;
      end
   endtask

   // Builds the next random expression into expr_q.
   task automatic build_expr();
      int mode;
      int levels;
      expr_q.delete();
      mode = $urandom_range(0, 99);
      if (mode < 60) begin
         gen_wellformed($urandom_range(0, 4), $urandom_range(0, 6));
      end else if (mode < 68) begin
         // Deep nesting that runs the stack close to full or over it. An
         // operand and operator in front of a group stack one more entry.
         levels = $urandom_range(26, 34);
         for (int i = 0; i < levels; i++) begin
            if ($urandom_range(0, 1)) begin
               expr_q.push_back(rand_alnum());
               expr_q.push_back(rand_op());
            end
            expr_q.push_back(CH_LPAREN);
         end
         expr_q.push_back(rand_alnum());
         for (int i = 0; i < levels; i++) expr_q.push_back(CH_RPAREN);
      end else if (mode < 85) begin
         // A well-formed expression with one defect.
         gen_wellformed($urandom_range(0, 3), $urandom_range(1, 5));
         case ($urandom_range(0, 3))
            0: expr_q.delete($urandom_range(0, expr_q.size() - 1));
            1: expr_q.insert($urandom_range(0, expr_q.size()), CH_RPAREN);
            2: expr_q.insert($urandom_range(0, expr_q.size()), CH_LPAREN);
            default: expr_q[$urandom_range(0, expr_q.size() - 1)] = 8'($urandom_range(0, 255));
         endcase
         if (expr_q.size() == 0) expr_q.push_back(rand_alnum());
      end else begin
         // Noise: any byte at all, or any known character in any order.
         for (int i = $urandom_range(1, 6); i > 0; i--) begin
            if ($urandom_range(0, 1)) expr_q.push_back(8'($urandom_range(0, 255)));
            else expr_q.push_back(rand_token());
         end
      end
   endtask

   // Offers one request and returns at the falling edge after it was taken.
   // Called at a falling edge.
   task automatic send_char(input logic [7:0] c, input logic fin, input logic typed,
                            input i2p_pkg::res_type want);
      while (sender_idles()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_ch       <= c;
      req_expr_end <= fin;
      row_typed    <= typed;
      row_want     <= want;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Sender: reset, then the directed table, then random expressions until
   // enough requests have gone in, then drain and give the verdict. The last
   // expression may be cut short; the predictor follows whatever was sent.
   initial begin : sender
      i2p_pkg::res_type want;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_ch       = 8'h00;
      req_expr_end = 1'b0;
      row_typed    = 1'b0;
      row_want     = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         want.symbol = dir_rows[i].symbol;
         want.kind   = dir_rows[i].kind;
         want.code   = dir_rows[i].code;
         want.last   = 1'b1;
         send_char(dir_rows[i].ch, dir_rows[i].fin, dir_rows[i].typed, want);
      end

      while (sent_items < ITEMS) begin
         build_expr();
         foreach (expr_q[i]) begin
            if (sent_items < ITEMS) begin
               send_char(expr_q[i], i == expr_q.size() - 1, 1'b0, '0);
            end
         end
      end
      req_valid <= 1'b0;

      // Wait for every owed result, then a little longer to catch strays.
      while (postfix_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Receiver: random stalls, a quiet window, and one long hold-off that
   // backs the block up until it stops taking requests.
   initial begin : receiver
      int  hold_left;
      bit  held;
      hold_left = 0;
      held      = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && live_items >= HOLD_AT) begin
            held      = 1'b1;
            hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= quiet_window() || $urandom_range(0, 99) >= IDLE_PCT;
         end
      end
   end

   // Monitor: checks each result against the oldest one owed, then predicts
   // the results of a request taken at the same edge. Doing both here keeps
   // the order of the store fixed.
   always @(posedge clock) begin
      i2p_pkg::res_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (postfix_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result, symbol %h kind %0d code %0d",
                                         rsp_symbol, rsp_kind, rsp_error_code));
            end else begin
               want = postfix_q.pop_front();
               if (rsp_symbol !== want.symbol)
                  report_mismatch($sformatf("symbol %h, wanted %h", rsp_symbol, want.symbol));
               if (rsp_kind !== want.kind)
                  report_mismatch($sformatf("kind %0d, wanted %0d", rsp_kind, want.kind));
               if (rsp_error_code !== want.code)
                  report_mismatch($sformatf("error code %0d, wanted %0d",
                                            rsp_error_code, want.code));
               if (rsp_run_last !== want.last)
                  report_mismatch($sformatf("run_last %b, wanted %b", rsp_run_last, want.last));
            end
            result_count++;
         end
         if (req_valid && req_ready) begin
            sent_items++;
            if (!dropping) live_items++;
            convert_char(req_ch, req_expr_end);
            // A typed row brings its own answer; the predictor still runs to
            // keep its stack in step with the block.
            if (row_typed) postfix_q.push_back(row_want);
            else foreach (step_q[i]) postfix_q.push_back(step_q[i]);
         end
      end
   end

   // Hard limit on the run, far above the slowest correct run.
   initial begin : watchdog
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// File: sim.f
design/i2p_pkg.sv
design/i2p_op_stack.sv
design/infix_to_postfix_converter.sv
design/i2p_checker.sv
dv/infix_to_postfix_converter_test.sv
